### design/i2cmbe_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine package
// Command codes, transaction payload types and default settings.
// ----------------------------------------------------------------------------
package i2cmbe_pkg;

  localparam int DELAY_WIDTH_DEF = 16;
  localparam int HP_WIDTH        = 16;
  localparam logic [HP_WIDTH-1:0] HP_RESET = 16'd10;

  localparam logic [2:0] CMD_START = 3'd0;
  localparam logic [2:0] CMD_STOP  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_READ  = 3'd3;
  localparam logic [2:0] CMD_ACK   = 3'd4;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] command;
    logic [7:0] write_byte;
    logic       sda_in;
  } in_item_t;

  // scl_out sits in bit 0
  typedef struct packed {
    logic       ack_received;
    logic [7:0] read_byte;
    logic       done_res;
    logic       busy_res;
    logic       sda_out;
    logic       scl_out;
  } res_t;

endpackage

### design/i2cmbe_in_reg.sv
// ----------------------------------------------------------------------------
// I2C master bit engine input register
// Holds one incoming tick until the engine can take it.
// ----------------------------------------------------------------------------
module i2cmbe_in_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2cmbe_pkg::in_item_t in_item,
  input  logic                 advance,
  output logic                 item_valid,
  output i2cmbe_pkg::in_item_t item
);
  import i2cmbe_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

endmodule

### design/i2cmbe_core.sv
// ----------------------------------------------------------------------------
// I2C master bit engine core
// Sequencer state and the per-tick half-period logic.
// ----------------------------------------------------------------------------
module i2cmbe_core #(
  parameter int DELAY_WIDTH = i2cmbe_pkg::DELAY_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  i2cmbe_pkg::in_item_t               item,
  input  logic [i2cmbe_pkg::HP_WIDTH-1:0]    half_period,
  output i2cmbe_pkg::res_t                   res
);
  import i2cmbe_pkg::*;

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ONE  = 2'd1;
  localparam logic [1:0] PH_TWO  = 2'd2;
  localparam logic [1:0] PH_THREE = 2'd3;
  localparam logic [32:0] DLY_MAX = (33'd1 << DELAY_WIDTH) - 33'd1;

  logic [1:0]             phase_r,  phase_nxt;
  logic [2:0]             cmd_r,    cmd_nxt;
  logic [3:0]             bit_r,    bit_nxt;
  logic [DELAY_WIDTH-1:0] dly_r,    dly_nxt;
  logic [7:0]             shift_r,  shift_nxt;
  logic                   scl_r,    scl_nxt;
  logic                   sda_r,    sda_nxt;
  logic                   ack_r,    ack_nxt;
  logic [7:0]             last_r,   last_nxt;
  logic                   done;
  logic [DELAY_WIDTH-1:0] reload;
  logic [DELAY_WIDTH-1:0] dly_dec;
  logic [3:0]             bit_inc;
  logic [7:0]             shift_w;

  // zero acts as one, saturate when the counter is narrower than the register
  always_comb begin
    if (half_period == '0) begin
      reload = DELAY_WIDTH'(1);
    end else if ({17'd0, half_period} > DLY_MAX) begin
      reload = '1;
    end else begin
      reload = DELAY_WIDTH'(half_period);
    end
  end

  assign dly_dec = (dly_r != '0) ? dly_r - DELAY_WIDTH'(1) : '0;
  assign bit_inc = bit_r + 4'd1;
  assign shift_w = {shift_r[6:0], 1'b0};

  always_comb begin
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    bit_nxt   = bit_r;
    dly_nxt   = dly_r;
    shift_nxt = shift_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    last_nxt  = last_r;
    done      = 1'b0;

    if (phase_r == PH_IDLE) begin
      if (item.cmd_valid && (item.command inside {[CMD_START:CMD_ACK]})) begin
        cmd_nxt   = item.command;
        bit_nxt   = 4'd0;
        phase_nxt = PH_ONE;
        scl_nxt   = 1'b1;
        sda_nxt   = 1'b1;
        dly_nxt   = reload;
        case (item.command)
          CMD_STOP: begin
            sda_nxt = 1'b0;
          end
          CMD_WRITE: begin
            shift_nxt = item.write_byte;
            sda_nxt   = item.write_byte[7];
          end
          CMD_READ: begin
            shift_nxt = 8'd0;
          end
          default: begin
          end
        endcase
      end
    end else begin
      dly_nxt = dly_dec;
      if (dly_dec == '0) begin
        dly_nxt = reload;
        case (cmd_r)
          CMD_START: begin
            if (phase_r == PH_ONE) begin
              phase_nxt = PH_TWO;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b0;
            end else if (phase_r == PH_TWO) begin
              phase_nxt = PH_THREE;
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b0;
            end else begin
              done = 1'b1;
            end
          end
          CMD_STOP: begin
            if (phase_r == PH_ONE) begin
              phase_nxt = PH_TWO;
              scl_nxt   = 1'b1;
              sda_nxt   = 1'b1;
            end else begin
              done = 1'b1;
            end
          end
          CMD_WRITE: begin
            if (phase_r == PH_ONE) begin
              phase_nxt = PH_TWO;
              scl_nxt   = 1'b0;
            end else begin
              shift_nxt = shift_w;
              bit_nxt   = bit_inc;
              if (bit_inc[3]) begin
                done = 1'b1;
              end else begin
                phase_nxt = PH_ONE;
                scl_nxt   = 1'b1;
                sda_nxt   = shift_w[7];
              end
            end
          end
          CMD_READ: begin
            if (phase_r == PH_ONE) begin
              shift_nxt = {shift_r[6:0], item.sda_in};
              phase_nxt = PH_TWO;
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b1;
            end else begin
              bit_nxt = bit_inc;
              if (bit_inc[3]) begin
                last_nxt = shift_r;
                done     = 1'b1;
              end else begin
                phase_nxt = PH_ONE;
                scl_nxt   = 1'b1;
                sda_nxt   = 1'b1;
              end
            end
          end
          default: begin
            if (phase_r == PH_ONE) begin
              ack_nxt   = !item.sda_in;
              phase_nxt = PH_TWO;
              scl_nxt   = 1'b0;
              sda_nxt   = 1'b1;
            end else begin
              done = 1'b1;
            end
          end
        endcase
        if (done) begin
          phase_nxt = PH_IDLE;
          dly_nxt   = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cmd_r   <= CMD_START;
      bit_r   <= 4'd0;
      dly_r   <= '0;
      shift_r <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      last_r  <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cmd_r   <= cmd_nxt;
      bit_r   <= bit_nxt;
      dly_r   <= dly_nxt;
      shift_r <= shift_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    res.scl_out      = scl_nxt;
    res.sda_out      = sda_nxt;
    res.busy_res     = (phase_nxt != PH_IDLE);
    res.done_res     = done;
    res.read_byte    = last_nxt;
    res.ack_received = ack_nxt;
  end

endmodule

### design/i2c_master_bit_engine_unit.sv
// ----------------------------------------------------------------------------
// I2C master bit engine
// Open-drain SCL/SDA sequencer for start, stop, write, read and ack commands.
// ----------------------------------------------------------------------------
// Each input transaction is one tick and gives one result transaction showing
// the line levels and status after that tick. One tick is taken every clock
// cycle unless out_tready stalls a held result; the path runs through the
// input register and the result register, with the sequencer's next-state
// logic between them. Half-periods last hp_r ticks (zero acts as one).
// Commands arriving while a sequence runs, and unknown codes, are ignored.
module i2c_master_bit_engine_unit #(
  parameter int DELAY_WIDTH = i2cmbe_pkg::DELAY_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // write_byte[7:0], sda_in[8], zero pad
  input  logic [3:0]  in_tuser,   // cmd_valid[0], command[3:1]
  output logic        out_tvalid,
  input  logic        out_tready,
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_byte[11:4],
  // ack_received[12], zero pad
  output logic [15:0] out_tdata,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);
  import i2cmbe_pkg::*;

  in_item_t          in_item;
  in_item_t          item;
  logic              item_valid;
  logic              advance;
  res_t              res;
  logic [HP_WIDTH-1:0] hp_r;
  logic              out_valid_r, out_valid_nxt;
  res_t              out_res_r;

  assign in_item.cmd_valid  = in_tuser[0];
  assign in_item.command    = in_tuser[3:1];
  assign in_item.write_byte = in_tdata[7:0];
  assign in_item.sda_in     = in_tdata[8];

  assign advance = item_valid && (!out_valid_r || out_tready);

  i2cmbe_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  i2cmbe_core #(
    .DELAY_WIDTH (DELAY_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .item        (item),
    .half_period (hp_r),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hp_r <= HP_RESET;
    end else if (cfg_wr_en) begin
      hp_r <= cfg_wr_data;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_res_r};

  a_done_clears_busy : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.done_res) |-> !out_res_r.busy_res)
    else $error("done reported while still busy");

  a_ready_when_empty : assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty result register");

  a_step_gives_result : assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("processed tick produced no result");

endmodule
